// File: src/tcb_pkg.sv
// Shared constants, types and helpers of the text cell buffer.
package tcb_pkg;

  // Buffer geometry
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 32;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ECOL_W      = $clog2(MAX_COLUMNS + 1);
  localparam int EROW_W      = $clog2(MAX_ROWS + 1);
  localparam int ROW_BITS    = MAX_COLUMNS * 8;

  // Port widths
  localparam int OPCODE_W  = 2;
  localparam int CODE_W    = 8;
  localparam int REPEAT_W  = 4;
  localparam int RCOL_W    = 7;
  localparam int RROW_W    = 5;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int CHAR_W    = 8;
  localparam int CFG_COL_W = 8;
  localparam int CFG_ROW_W = 6;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam int         TAB_STOP = 8;

  // Virtual key codes
  localparam logic [7:0] KEY_PRIOR  = 8'h21;
  localparam logic [7:0] KEY_NEXT   = 8'h22;
  localparam logic [7:0] KEY_END    = 8'h23;
  localparam logic [7:0] KEY_HOME   = 8'h24;
  localparam logic [7:0] KEY_LEFT   = 8'h25;
  localparam logic [7:0] KEY_UP     = 8'h26;
  localparam logic [7:0] KEY_RIGHT  = 8'h27;
  localparam logic [7:0] KEY_DOWN   = 8'h28;
  localparam logic [7:0] KEY_DELETE = 8'h2E;

  // Reset values of the geometry registers
  localparam logic [CFG_COL_W-1:0] COLS_RESET = CFG_COL_W'(80);
  localparam logic [CFG_ROW_W-1:0] ROWS_RESET = CFG_ROW_W'(25);

  typedef enum logic [OPCODE_W-1:0] {
    OP_KEY,
    OP_CHAR,
    OP_READ,
    OP_CLEAR
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS,
    CFG_ROWS
  } cfg_reg_e;

  // Edit applied to one row read from the cell memory
  typedef enum logic [1:0] {
    ROW_DELETE,
    ROW_PUT,
    ROW_BLANK,
    ROW_READ
  } row_op_e;

  typedef logic [MAX_COLUMNS-1:0][7:0] row_t;

  typedef struct packed {
    row_op_e            op;
    logic [COL_W-1:0]   col;
    logic [7:0]         ch;
    logic [ECOL_W-1:0]  cols;
  } row_cmd_t;

  // Columns in use, with zero taken as one and large values saturated
  function automatic logic [ECOL_W-1:0] eff_cols_f(input logic [CFG_COL_W-1:0] v);
    logic [ECOL_W-1:0] res;
    if (int'(v) == 0) begin
      res = ECOL_W'(1);
    end else if (int'(v) > MAX_COLUMNS) begin
      res = ECOL_W'(MAX_COLUMNS);
    end else begin
      res = ECOL_W'(v);
    end
    return res;
  endfunction

  // Rows in use, with zero taken as one and large values saturated
  function automatic logic [EROW_W-1:0] eff_rows_f(input logic [CFG_ROW_W-1:0] v);
    logic [EROW_W-1:0] res;
    if (int'(v) == 0) begin
      res = EROW_W'(1);
    end else if (int'(v) > MAX_ROWS) begin
      res = EROW_W'(MAX_ROWS);
    end else begin
      res = EROW_W'(v);
    end
    return res;
  endfunction

endpackage

// File: src/tcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tcb_row_edit.sv
// Row modifier: delete-shift, character store and blanking on one buffer row.
module tcb_row_edit (
  input  tcb_pkg::row_t     row_in,
  input  tcb_pkg::row_cmd_t cmd,
  output tcb_pkg::row_t     row_out,
  output logic [7:0]        cell_char
);
  import tcb_pkg::*;

  row_t shifted;

  // Row moved one cell left, space entering at the far end
  assign shifted = {CH_SPACE, row_in[MAX_COLUMNS-1:1]};

  // Pick the cell under the selected column
  assign cell_char = row_in[cmd.col];

  // Apply the edit cell by cell
  always_comb begin
    row_out = row_in;
    for (int x = 0; x < MAX_COLUMNS; x++) begin
      unique case (cmd.op)
        ROW_DELETE: begin
          if (x >= int'(cmd.col) && x + 1 < int'(cmd.cols)) begin
            row_out[x] = shifted[x];
          end else if (x == int'(cmd.cols) - 1) begin
            row_out[x] = CH_SPACE;
          end
        end
        ROW_PUT: begin
          if (x == int'(cmd.col)) begin
            row_out[x] = cmd.ch;
          end
        end
        ROW_BLANK: begin
          if (x >= int'(cmd.col) && x < int'(cmd.cols)) begin
            row_out[x] = CH_SPACE;
          end
        end
        ROW_READ: begin
          row_out[x] = row_in[x];
        end
        default: begin
          row_out[x] = row_in[x];
        end
      endcase
    end
  end

endmodule

// File: src/text_cell_buffer_with_caret.sv
// Top level of the text cell buffer: transaction sequencer around the row memory.
//
// Character-cell text buffer with a caret. Cells live in one row-wide memory
// (one entry per row, all columns side by side); every edit reads a row,
// modifies it and writes it back via S_READ and S_MOD. Caret-only keys,
// unknown keys and out-of-range reads go straight to S_DONE; a cell read or
// a delete passes S_READ and S_MOD once. A character event takes, for each
// repeat, one decode step in S_CHAR and a read and write-back per row: one
// for a stored character or a backspace, one per space of a tab (up to 8),
// and one per row from the caret row to the last row in use for an escape;
// newline, carriage return and a backspace in column 0 need only the decode
// step. A clear-all sweeps all MAX_ROWS rows to space. After reset and after
// every write of a geometry register the block sweeps all MAX_ROWS rows to
// space with in_stall high. A finished result sits in the output register,
// and the next transaction is taken while it waits.
module text_cell_buffer_with_caret (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tcb_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [tcb_pkg::CODE_W-1:0]        in_code,
  input  logic [tcb_pkg::REPEAT_W-1:0]      in_repeat_count,
  input  logic [tcb_pkg::RCOL_W-1:0]        in_read_column,
  input  logic [tcb_pkg::RROW_W-1:0]        in_read_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcb_pkg::OUT_COL_W-1:0]     out_caret_column,
  output logic [tcb_pkg::OUT_ROW_W-1:0]     out_caret_row,
  output logic [tcb_pkg::CHAR_W-1:0]        out_cell_char,
  input  logic                              cfg_we,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcb_pkg::CFG_W-1:0]         cfg_wdata
);
  import tcb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_CHAR,
    S_READ,
    S_MOD,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  row_op_e                job_r, job_nxt;
  opcode_e                opc_r, opc_nxt;
  logic [CODE_W-1:0]      code_r, code_nxt;
  logic [REPEAT_W-1:0]    count_r, count_nxt;
  logic [COL_W-1:0]       rcol_r, rcol_nxt;
  logic [ROW_W-1:0]       rrow_r, rrow_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [ROW_W-1:0]       esc_row_r, esc_row_nxt;
  logic [ROW_W-1:0]       clr_row_r, clr_row_nxt;
  logic                   clr_reply_r, clr_reply_nxt;
  logic [CHAR_W-1:0]      cell_r, cell_nxt;
  logic [CFG_COL_W-1:0]   cols_cfg_r, cols_cfg_nxt;
  logic [CFG_ROW_W-1:0]   rows_cfg_r, rows_cfg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_COL_W-1:0]   out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;

  logic [ECOL_W-1:0]      cols_eff;
  logic [EROW_W-1:0]      rows_eff;
  logic [ECOL_W-1:0]      col_inc;
  logic [EROW_W-1:0]      row_inc;
  logic [EROW_W-1:0]      esc_inc;
  logic [ROW_W-1:0]       row_next;
  logic [COL_W-1:0]       col_put;
  logic                   col_wrap;

  logic                   mem_we;
  logic [ROW_W-1:0]       mem_addr;
  row_t                   mem_wdata;
  row_t                   mem_rdata;
  row_t                   edit_row;
  row_cmd_t               edit_cmd;
  logic [7:0]             edit_cell;

  logic                   in_take;
  logic                   out_free;

  // Geometry in use and caret arithmetic
  assign cols_eff = eff_cols_f(cols_cfg_r);
  assign rows_eff = eff_rows_f(rows_cfg_r);
  assign col_inc  = ECOL_W'(col_r) + ECOL_W'(1);
  assign row_inc  = EROW_W'(row_r) + EROW_W'(1);
  assign esc_inc  = EROW_W'(esc_row_r) + EROW_W'(1);
  assign row_next = (row_inc >= rows_eff) ? '0 : ROW_W'(row_inc);
  assign col_wrap = (col_inc >= cols_eff);
  assign col_put  = col_wrap ? '0 : COL_W'(col_inc);

  // Handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_caret_column = out_col_r;
  assign out_caret_row    = out_row_r;
  assign out_cell_char    = out_char_r;

  // Row address for the current job
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_addr = clr_row_r;
    end else begin
      unique case (job_r)
        ROW_BLANK: mem_addr = esc_row_r;
        ROW_READ:  mem_addr = rrow_r;
        default:   mem_addr = row_r;
      endcase
    end
  end

  // Edit command for the row modifier
  always_comb begin
    edit_cmd.op   = job_r;
    edit_cmd.col  = (job_r == ROW_READ) ? rcol_r : col_r;
    edit_cmd.ch   = (code_r == CH_TAB) ? CH_SPACE : code_r;
    edit_cmd.cols = cols_eff;
  end

  // Write back edited rows, or blank rows during a sweep
  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_MOD && job_r != ROW_READ);
  assign mem_wdata = (state_r == S_CLEAR) ? row_t'({MAX_COLUMNS{CH_SPACE}}) : edit_row;

  tcb_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(MAX_ROWS)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_addr),
    .wdata(mem_wdata),
    .raddr(mem_addr),
    .rdata(mem_rdata)
  );

  tcb_row_edit u_edit (
    .row_in   (mem_rdata),
    .cmd      (edit_cmd),
    .row_out  (edit_row),
    .cell_char(edit_cell)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    opc_nxt       = opc_r;
    code_nxt      = code_r;
    count_nxt     = count_r;
    rcol_nxt      = rcol_r;
    rrow_nxt      = rrow_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    esc_row_nxt   = esc_row_r;
    clr_row_nxt   = clr_row_r;
    clr_reply_nxt = clr_reply_r;
    cell_nxt      = cell_r;
    cols_cfg_nxt  = cols_cfg_r;
    rows_cfg_nxt  = rows_cfg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_char_nxt  = out_char_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          opc_nxt  = opcode_e'(in_opcode);
          code_nxt = in_code;
          cell_nxt = '0;
          unique case (opcode_e'(in_opcode))
            OP_KEY: begin
              state_nxt = S_DONE;
              unique case (in_code)
                KEY_HOME:  col_nxt = '0;
                KEY_END:   col_nxt = COL_W'(cols_eff - ECOL_W'(1));
                KEY_PRIOR: row_nxt = '0;
                KEY_NEXT:  row_nxt = ROW_W'(rows_eff - EROW_W'(1));
                KEY_LEFT: begin
                  if (col_r != '0) col_nxt = col_r - COL_W'(1);
                end
                KEY_RIGHT: begin
                  if (!col_wrap) col_nxt = COL_W'(col_inc);
                end
                KEY_UP: begin
                  if (row_r != '0) row_nxt = row_r - ROW_W'(1);
                end
                KEY_DOWN: begin
                  if (row_inc < rows_eff) row_nxt = ROW_W'(row_inc);
                end
                KEY_DELETE: begin
                  job_nxt   = ROW_DELETE;
                  state_nxt = S_READ;
                end
                default: begin
                  state_nxt = S_DONE;
                end
              endcase
            end
            OP_CHAR: begin
              count_nxt = in_repeat_count;
              state_nxt = S_CHAR;
            end
            OP_READ: begin
              rcol_nxt = COL_W'(in_read_column);
              rrow_nxt = ROW_W'(in_read_row);
              if (32'(in_read_column) < 32'(cols_eff) && 32'(in_read_row) < 32'(rows_eff)) begin
                job_nxt   = ROW_READ;
                state_nxt = S_READ;
              end else begin
                cell_nxt  = CH_SPACE;
                state_nxt = S_DONE;
              end
            end
            OP_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              clr_row_nxt   = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Sweep every row to space
      S_CLEAR: begin
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(MAX_ROWS - 1)) begin
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end

      // Start one repeat of a character event
      S_CHAR: begin
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          priority case (code_r)
            CH_BS: begin
              if (col_r != '0) begin
                col_nxt   = col_r - COL_W'(1);
                job_nxt   = ROW_DELETE;
                state_nxt = S_READ;
              end else begin
                count_nxt = count_r - REPEAT_W'(1);
              end
            end
            CH_LF: begin
              row_nxt   = row_next;
              count_nxt = count_r - REPEAT_W'(1);
            end
            CH_CR: begin
              col_nxt   = '0;
              row_nxt   = row_next;
              count_nxt = count_r - REPEAT_W'(1);
            end
            CH_ESC: begin
              esc_row_nxt = row_r;
              job_nxt     = ROW_BLANK;
              state_nxt   = S_READ;
            end
            default: begin
              job_nxt   = ROW_PUT;
              state_nxt = S_READ;
            end
          endcase
        end
      end

      // Row read issued; data arrives next cycle
      S_READ: begin
        state_nxt = S_MOD;
      end

      // Modify and write back the row
      S_MOD: begin
        unique case (job_r)
          ROW_READ: begin
            cell_nxt  = edit_cell;
            state_nxt = S_DONE;
          end
          ROW_DELETE: begin
            if (opc_r == OP_KEY) begin
              state_nxt = S_DONE;
            end else begin
              count_nxt = count_r - REPEAT_W'(1);
              state_nxt = S_CHAR;
            end
          end
          ROW_PUT: begin
            col_nxt = col_put;
            if (col_wrap) row_nxt = row_next;
            if (code_r == CH_TAB && (col_put & COL_W'(TAB_STOP - 1)) != '0) begin
              state_nxt = S_READ;
            end else begin
              count_nxt = count_r - REPEAT_W'(1);
              state_nxt = S_CHAR;
            end
          end
          ROW_BLANK: begin
            if (esc_inc < rows_eff) begin
              esc_row_nxt = ROW_W'(esc_inc);
              state_nxt   = S_READ;
            end else begin
              col_nxt   = '0;
              row_nxt   = '0;
              count_nxt = count_r - REPEAT_W'(1);
              state_nxt = S_CHAR;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = OUT_COL_W'(col_r);
          out_row_nxt   = OUT_ROW_W'(row_r);
          out_char_nxt  = cell_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Geometry write: resize, home the caret and sweep the buffer
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_COLUMNS: cols_cfg_nxt = CFG_COL_W'(cfg_wdata);
        CFG_ROWS:    rows_cfg_nxt = CFG_ROW_W'(cfg_wdata);
        default:     cols_cfg_nxt = cols_cfg_r;
      endcase
      col_nxt       = '0;
      row_nxt       = '0;
      clr_row_nxt   = '0;
      clr_reply_nxt = 1'b0;
      state_nxt     = S_CLEAR;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      job_r       <= ROW_READ;
      opc_r       <= OP_KEY;
      col_r       <= '0;
      row_r       <= '0;
      clr_row_r   <= '0;
      clr_reply_r <= 1'b0;
      count_r     <= '0;
      cols_cfg_r  <= COLS_RESET;
      rows_cfg_r  <= ROWS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      opc_r       <= opc_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      clr_row_r   <= clr_row_nxt;
      clr_reply_r <= clr_reply_nxt;
      count_r     <= count_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r     <= code_nxt;
    rcol_r     <= rcol_nxt;
    rrow_r     <= rrow_nxt;
    esc_row_r  <= esc_row_nxt;
    cell_r     <= cell_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_char_r <= out_char_nxt;
  end

endmodule
